// ===== hdl/pjd_pkg.sv =====
// package: widths, constants and types for the parallel job dispatcher
package pjd_pkg;
  localparam int unsigned MaxMachinesDef = 64;
  localparam int unsigned CountW = 7;
  localparam int unsigned TimeW = 32;
  localparam int unsigned InTimeW = 30;
  localparam int unsigned IdOutW = 6;
  localparam int unsigned CfgAddrW = 1;
  localparam logic [CfgAddrW-1:0] RegMachineCount = 1'b0;

  typedef struct packed {
    logic [InTimeW-1:0] arrival_time;
    logic [InTimeW-1:0] job_length;
    logic               final_job;
  } job_t;

  typedef struct packed {
    logic [IdOutW-1:0] machine_id;
    logic [TimeW-1:0]  start_time;
    logic [TimeW-1:0]  overall_finish;
    logic              is_last;
  } result_t;
endpackage

// ===== hdl/pjd_stream_if.sv =====
// valid/ready channel interface carrying one payload type
interface pjd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/parallel_job_dispatcher.sv =====
// top level: job dispatcher with free and busy min-heaps held in memories
//
// channels: job_in (arrival_time, job_length, final_job) and res_out
// (machine_id, start_time, overall_finish, is_last), valid/ready each; one
// result transaction per job transaction, in order
// apb port: machine_count at address 0; a write empties the busy heap, zeroes
// the time and refills the free heap through a sweep over all MaxMachines
// entries, during which no job is taken
// each heap lives in a synchronous memory; a push sifts up one level at a time
// (read parent, then compare/write), a pop sifts down one level at a time
// (read left child, read right child, then compare/write). each released
// machine is a busy pop then a free push, and a final job drains all busy
// machines the same way. one job is worked on at a time and the block is
// ready again in the cycle after its result is taken
// after reset the free heap is filled by the same sweep with machines
// 0..MaxMachines-1; the result waits in an output register while the receiver
// stalls and the next job is taken only when it has gone
module parallel_job_dispatcher #(
  parameter int unsigned MaxMachines = pjd_pkg::MaxMachinesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pjd_stream_if.sink                   job_in,
  pjd_stream_if.source                 res_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pjd_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import pjd_pkg::*;

  localparam int unsigned AW = $clog2(MaxMachines);
  localparam int unsigned NW = AW + 1;
  localparam int unsigned IdW = AW;
  localparam int unsigned BW = TimeW + IdW;

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHK    = 5'd2;
  localparam logic [4:0] S_BPOP0  = 5'd3;
  localparam logic [4:0] S_BPOPR  = 5'd4;
  localparam logic [4:0] S_BPOPC  = 5'd5;
  localparam logic [4:0] S_FPUSH  = 5'd6;
  localparam logic [4:0] S_FPUSHC = 5'd7;
  localparam logic [4:0] S_FPOP0  = 5'd8;
  localparam logic [4:0] S_FPOPR  = 5'd9;
  localparam logic [4:0] S_FPOPC  = 5'd10;
  localparam logic [4:0] S_BPUSH  = 5'd11;
  localparam logic [4:0] S_BPUSHC = 5'd12;
  localparam logic [4:0] S_DONE   = 5'd13;
  localparam logic [4:0] S_OUT    = 5'd14;
  localparam logic [4:0] S_FPOPL  = 5'd15;
  localparam logic [4:0] S_BPOPL  = 5'd16;
  localparam logic [4:0] S_FPUSHR = 5'd17;
  localparam logic [4:0] S_BPUSHR = 5'd18;

  logic [4:0] st_q, st_d;
  logic [CountW-1:0] mcount_q, mcount_d;
  logic [NW-1:0] fcnt_q, fcnt_d, bcnt_q, bcnt_d;
  logic [TimeW-1:0] now_q, now_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [AW-1:0] sib_q, sib_d;
  logic [BW-1:0] cur_q, cur_d, tmp_q, tmp_d;
  logic [IdW-1:0] popped_q, popped_d;
  logic [InTimeW-1:0] arr_q, arr_d, len_q, len_d;
  logic last_q, last_d, draining_q, draining_d;
  logic [1:0] cph_q, cph_d;
  result_t res_q, res_d;
  logic res_v_q, res_v_d;

  logic f_we, b_we;
  logic [AW-1:0] f_wa, f_ra, b_wa, b_ra;
  logic [IdW-1:0] f_wd, f_rd;
  logic [BW-1:0] b_wd, b_rd;

  pjd_heap_mem #(.Depth(MaxMachines), .Width(IdW)) u_free (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(f_wd), .raddr_i(f_ra), .rdata_o(f_rd)
  );
  pjd_heap_mem #(.Depth(MaxMachines), .Width(BW)) u_busy (
    .clk_i, .we_i(b_we), .waddr_i(b_wa), .wdata_i(b_wd), .raddr_i(b_ra), .rdata_o(b_rd)
  );

  logic cfg_wr;
  logic [CountW-1:0] wr_cnt;
  logic [32:0] sum;
  logic [NW-1:0] par, lc, rc;

  assign pready = 1'b1;
  assign prdata = {{(32-CountW){1'b0}}, mcount_q};
  assign cfg_wr = psel & penable & pwrite & (paddr == RegMachineCount);
  assign job_in.ready = (st_q == S_IDLE) & ~res_v_q;
  assign res_out.valid = res_v_q;
  assign res_out.data = res_q;

  always_comb begin
    wr_cnt = pwdata[CountW-1:0];
    if (wr_cnt == '0) wr_cnt = CountW'(1);
    if ({25'd0, wr_cnt} > 32'(MaxMachines)) wr_cnt = CountW'(MaxMachines);
  end

  assign par = (idx_q - NW'(1)) >> 1;
  assign lc = NW'({idx_q, 1'b0} + 1);
  assign rc = lc + NW'(1);
  assign sum = {1'b0, now_q} + {3'b0, len_q};

  always_comb begin
    st_d = st_q; mcount_d = mcount_q; fcnt_d = fcnt_q; bcnt_d = bcnt_q;
    now_d = now_q; idx_d = idx_q; sib_d = sib_q; cur_d = cur_q; tmp_d = tmp_q;
    popped_d = popped_q; arr_d = arr_q; len_d = len_q; last_d = last_q;
    draining_d = draining_q; cph_d = cph_q; res_d = res_q; res_v_d = res_v_q;
    f_we = 1'b0; f_wa = idx_q[AW-1:0]; f_wd = cur_q[IdW-1:0]; f_ra = '0;
    b_we = 1'b0; b_wa = idx_q[AW-1:0]; b_wd = cur_q; b_ra = '0;

    if (res_v_q && res_out.ready) res_v_d = 1'b0;

    case (st_q)
      S_INIT: begin
        f_we = 1'b1;
        f_wd = idx_q[IdW-1:0];
        if (idx_q == NW'(MaxMachines - 1)) st_d = S_IDLE;
        else idx_d = idx_q + NW'(1);
      end
      S_IDLE: begin
        if (job_in.valid && job_in.ready) begin
          arr_d = job_in.data.arrival_time;
          len_d = job_in.data.job_length;
          last_d = job_in.data.final_job;
          draining_d = 1'b0;
          st_d = S_CHK;
        end
      end
      S_CHK: begin
        b_ra = '0;
        st_d = S_BPOP0;
      end
      S_BPOP0: begin
        // b_rd is busy root
        if (bcnt_q != '0 && (draining_q || fcnt_q == '0 ||
            b_rd[BW-1:IdW] <= {2'b0, arr_q})) begin
          popped_d = b_rd[IdW-1:0];
          now_d = b_rd[BW-1:IdW];
          bcnt_d = bcnt_q - NW'(1);
          b_ra = AW'(bcnt_q - NW'(1));
          st_d = S_BPOPL;
        end else if (draining_q) begin
          res_d.overall_finish = now_q;
          st_d = S_OUT;
        end else if (fcnt_q != '0) begin
          if ({2'b0, arr_q} > now_q) now_d = {2'b0, arr_q};
          f_ra = '0;
          st_d = S_FPOP0;
        end else begin
          st_d = S_DONE;
        end
      end
      S_BPOPL: begin
        cur_d = b_rd;
        idx_d = '0;
        st_d = S_BPOPR;
        cph_d = 2'd0;
      end
      S_BPOPR: begin
        // sift down: read the left child, then the right child, then keep the smaller
        if (lc >= bcnt_q) begin
          b_we = 1'b1; b_wd = cur_q;
          st_d = S_FPUSH;
        end else if (cph_q == 2'd0) begin
          b_ra = lc[AW-1:0]; cph_d = 2'd1;
        end else if (cph_q == 2'd1) begin
          tmp_d = b_rd;
          b_ra = (rc < bcnt_q) ? rc[AW-1:0] : lc[AW-1:0];
          sib_d = (rc < bcnt_q) ? rc[AW-1:0] : lc[AW-1:0];
          cph_d = 2'd2;
        end else begin
          st_d = S_BPOPC;
          if (b_rd[BW-1:IdW] < tmp_q[BW-1:IdW]) tmp_d = b_rd;
          else sib_d = lc[AW-1:0];
        end
      end
      S_BPOPC: begin
        cph_d = 2'd0;
        if (cur_q[BW-1:IdW] <= tmp_q[BW-1:IdW]) begin
          b_we = 1'b1; b_wd = cur_q;
          st_d = S_FPUSH;
        end else begin
          b_we = 1'b1; b_wd = tmp_q;
          idx_d = {1'b0, sib_q};
          st_d = S_BPOPR;
        end
      end
      S_FPUSH: begin
        if (fcnt_q >= NW'(MaxMachines)) begin
          st_d = S_CHK;
        end else begin
          idx_d = fcnt_q;
          fcnt_d = fcnt_q + NW'(1);
          cur_d = {{TimeW{1'b0}}, popped_q};
          st_d = S_FPUSHR;
        end
      end
      S_FPUSHR: begin
        if (idx_q == '0) begin
          f_we = 1'b1; f_wd = cur_q[IdW-1:0];
          st_d = S_CHK;
        end else begin
          f_ra = par[AW-1:0];
          st_d = S_FPUSHC;
        end
      end
      S_FPUSHC: begin
        f_we = 1'b1;
        if (cur_q[IdW-1:0] < f_rd) begin
          f_wd = f_rd;
          idx_d = par;
          st_d = S_FPUSHR;
        end else begin
          f_wd = cur_q[IdW-1:0];
          st_d = S_CHK;
        end
      end
      S_FPOP0: begin
        res_d.machine_id = IdOutW'(f_rd);
        fcnt_d = fcnt_q - NW'(1);
        f_ra = AW'(fcnt_q - NW'(1));
        st_d = S_FPOPL;
      end
      S_FPOPL: begin
        cur_d = {{TimeW{1'b0}}, f_rd};
        idx_d = '0;
        cph_d = 2'd0;
        st_d = S_FPOPR;
      end
      S_FPOPR: begin
        if (lc >= fcnt_q) begin
          f_we = 1'b1; f_wd = cur_q[IdW-1:0];
          st_d = S_BPUSH;
        end else if (cph_q == 2'd0) begin
          f_ra = lc[AW-1:0]; cph_d = 2'd1;
        end else if (cph_q == 2'd1) begin
          tmp_d = {{TimeW{1'b0}}, f_rd};
          f_ra = (rc < fcnt_q) ? rc[AW-1:0] : lc[AW-1:0];
          sib_d = (rc < fcnt_q) ? rc[AW-1:0] : lc[AW-1:0];
          cph_d = 2'd2;
        end else begin
          st_d = S_FPOPC;
          if (f_rd < tmp_q[IdW-1:0]) tmp_d = {{TimeW{1'b0}}, f_rd};
          else sib_d = lc[AW-1:0];
        end
      end
      S_FPOPC: begin
        cph_d = 2'd0;
        f_we = 1'b1;
        if (cur_q[IdW-1:0] <= tmp_q[IdW-1:0]) begin
          f_wd = cur_q[IdW-1:0];
          st_d = S_BPUSH;
        end else begin
          f_wd = tmp_q[IdW-1:0];
          idx_d = {1'b0, sib_q};
          st_d = S_FPOPR;
        end
      end
      S_BPUSH: begin
        cur_d = {(sum[32] ? {TimeW{1'b1}} : sum[TimeW-1:0]), res_q.machine_id[IdW-1:0]};
        if (bcnt_q >= NW'(MaxMachines)) begin
          st_d = S_DONE;
        end else begin
          idx_d = bcnt_q;
          bcnt_d = bcnt_q + NW'(1);
          st_d = S_BPUSHR;
        end
      end
      S_BPUSHR: begin
        if (idx_q == '0) begin
          b_we = 1'b1; b_wd = cur_q;
          st_d = S_DONE;
        end else begin
          b_ra = par[AW-1:0];
          st_d = S_BPUSHC;
        end
      end
      S_BPUSHC: begin
        b_we = 1'b1;
        if (cur_q[BW-1:IdW] < b_rd[BW-1:IdW]) begin
          b_wd = b_rd;
          idx_d = par;
          st_d = S_BPUSHR;
        end else begin
          b_wd = cur_q;
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (fcnt_q == '0 && bcnt_q == '0) res_d.machine_id = '0;
        res_d.start_time = now_q;
        res_d.is_last = last_q;
        res_d.overall_finish = '0;
        if (last_q) begin
          draining_d = 1'b1;
          st_d = S_CHK;
        end else begin
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        res_v_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase

    if (cfg_wr) begin
      mcount_d = wr_cnt;
      fcnt_d = NW'(wr_cnt);
      bcnt_d = '0;
      now_d = '0;
      idx_d = '0;
      st_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT;
      mcount_q <= CountW'(MaxMachines > 64 ? 64 : MaxMachines);
      fcnt_q <= NW'(MaxMachines > 64 ? 64 : MaxMachines);
      bcnt_q <= '0;
      now_q <= '0;
      idx_q <= '0;
      res_v_q <= 1'b0;
      draining_q <= 1'b0;
      cph_q <= '0;
    end else begin
      st_q <= st_d;
      mcount_q <= mcount_d;
      fcnt_q <= fcnt_d;
      bcnt_q <= bcnt_d;
      now_q <= now_d;
      idx_q <= idx_d;
      res_v_q <= res_v_d;
      draining_q <= draining_d;
      cph_q <= cph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sib_q <= sib_d; cur_q <= cur_d; tmp_q <= tmp_d; popped_q <= popped_d;
    arr_q <= arr_d; len_q <= len_d; last_q <= last_d; res_q <= res_d;
  end
endmodule

// ===== hdl/pjd_heap_mem.sv =====
// synchronous single-port-write, one-read memory with registered read data
module pjd_heap_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/pjd_checker.sv =====
// port-level checker for the dispatcher, bound to the top level
module pjd_port_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input pjd_pkg::result_t out_data_i,
  input logic             pready
);
  import pjd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped under stall");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("job taken while result pending");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.is_last |-> out_data_i.overall_finish == '0)
    else $error("finish time on non-final result");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_last |->
      out_data_i.overall_finish >= out_data_i.start_time)
    else $error("finish before start");
  a_rdy: assert property (@(posedge clk_i) pready)
    else $error("pready low");
endmodule

bind parallel_job_dispatcher pjd_port_checker u_pjd_port_checker (
  .clk_i, .rst_ni,
  .in_valid_i(job_in.valid), .in_ready_i(job_in.ready),
  .out_valid_i(res_out.valid), .out_ready_i(res_out.ready),
  .out_data_i(res_out.data), .pready
);
